@@ src/life_pkg.sv @@
`default_nettype none

package life_pkg;

   localparam int ROW_WIDTH       = 64;
   localparam int COLS_WIDTH      = 7;
   localparam int NBR_WIDTH       = 4;
   localparam int BIRTH_COUNT     = 3;
   localparam int SURVIVE_LOW     = 2;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [COLS_WIDTH-1:0] COLS_RESET = COLS_WIDTH'(ROW_WIDTH);

   typedef enum logic [1:0] {
      SEEN_NONE,
      SEEN_ONE,
      SEEN_TWO
   } seen_type;

   typedef struct packed {
      logic [ROW_WIDTH-1:0] up;
      logic [ROW_WIDTH-1:0] mid;
      logic [ROW_WIDTH-1:0] down;
      logic                 frame_end;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

@@ src/life_front.sv @@
`default_nettype none

module life_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [life_pkg::ROW_WIDTH-1:0] req_row_cells,
   input  wire logic                           req_bottom_row,
   input  wire life_pkg::queue_status_type     queue_status,
   output logic                                push_valid,
   output life_pkg::job_type                   push_job
);
   import life_pkg::*;

   seen_type             seen_ff;
   seen_type             seen_in;
   logic                 flush_pending_ff;
   logic                 flush_pending_in;
   logic [ROW_WIDTH-1:0] row_above_ff;
   logic [ROW_WIDTH-1:0] row_above_in;
   logic [ROW_WIDTH-1:0] row_current_ff;
   logic [ROW_WIDTH-1:0] row_current_in;
   logic                 accept;

   assign req_stall = queue_status.full || flush_pending_ff;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      seen_in          = seen_ff;
      flush_pending_in = flush_pending_ff && queue_status.full;
      row_above_in     = row_above_ff;
      row_current_in   = row_current_ff;
      if (accept) begin
         case (seen_ff)
            SEEN_NONE: begin
               row_above_in   = '0;
               row_current_in = req_row_cells;
               if (!req_bottom_row) begin
                  seen_in = SEEN_ONE;
               end
            end
            SEEN_ONE, SEEN_TWO: begin
               row_above_in   = row_current_ff;
               row_current_in = req_row_cells;
               if (req_bottom_row) begin
                  seen_in          = SEEN_NONE;
                  flush_pending_in = 1'b1;
               end else begin
                  seen_in = SEEN_TWO;
               end
            end
            default: begin
               seen_in = SEEN_NONE;
            end
         endcase
      end
   end

   always_comb begin
      push_valid         = 1'b0;
      push_job.up        = row_above_ff;
      push_job.mid       = row_current_ff;
      push_job.down      = req_row_cells;
      push_job.frame_end = 1'b0;
      if (flush_pending_ff) begin
         push_valid         = !queue_status.full;
         push_job.down      = '0;
         push_job.frame_end = 1'b1;
      end else if (accept) begin
         case (seen_ff)
            SEEN_NONE: begin
               push_valid         = req_bottom_row;
               push_job.up        = '0;
               push_job.mid       = req_row_cells;
               push_job.down      = '0;
               push_job.frame_end = 1'b1;
            end
            SEEN_ONE, SEEN_TWO: begin
               push_valid = 1'b1;
            end
            default: begin
               push_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff          <= SEEN_NONE;
         flush_pending_ff <= 1'b0;
      end else begin
         seen_ff          <= seen_in;
         flush_pending_ff <= flush_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      row_above_ff   <= row_above_in;
      row_current_ff <= row_current_in;
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (flush_pending_ff && !queue_status.full) |=> !flush_pending_ff)
      else $error("flush beat held after its push");
   assert property (@(posedge clock) disable iff (reset)
      flush_pending_ff |-> seen_ff == SEEN_NONE)
      else $error("flush pending while a frame is still open");
   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !queue_status.full)
      else $error("push into a full queue");
`endif

endmodule

`default_nettype wire

@@ src/life_queue.sv @@
`default_nettype none

module life_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push_valid,
   input  wire life_pkg::job_type          push_job,
   input  wire logic                       pop,
   output life_pkg::job_type               head_job,
   output life_pkg::queue_status_type      queue_status
);
   import life_pkg::*;

   job_type                    slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff;
   logic [QUEUE_CNT_WIDTH-1:0] count_in;
   logic                       do_push;
   logic                       do_pop;

   assign queue_status.full  = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign do_push  = push_valid && !queue_status.full;
   assign do_pop   = pop && !queue_status.empty;
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");
   assert property (@(posedge clock) disable iff (reset)
      queue_status.empty |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

@@ src/life_back.sv @@
`default_nettype none

module life_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [life_pkg::COLS_WIDTH-1:0] csr_columns_in_use,
   input  wire life_pkg::job_type               head_job,
   input  wire life_pkg::queue_status_type      queue_status,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [life_pkg::ROW_WIDTH-1:0]       rsp_next_cells,
   output logic                                 rsp_frame_end
);
   import life_pkg::*;

   logic [COLS_WIDTH-1:0] columns_ff;
   logic [ROW_WIDTH-1:0]  mask;
   logic [ROW_WIDTH+1:0]  up_pad;
   logic [ROW_WIDTH+1:0]  mid_pad;
   logic [ROW_WIDTH+1:0]  down_pad;
   logic [ROW_WIDTH-1:0]  next_row;
   logic [NBR_WIDTH-1:0]  nbr [ROW_WIDTH];
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [ROW_WIDTH-1:0]  rsp_cells_ff;
   logic                  rsp_frame_end_ff;

   always_comb begin
      for (int c = 0; c < ROW_WIDTH; c++) begin
         mask[c] = (COLS_WIDTH'(c) < columns_ff);
      end
   end

   assign up_pad   = {1'b0, head_job.up   & mask, 1'b0};
   assign mid_pad  = {1'b0, head_job.mid  & mask, 1'b0};
   assign down_pad = {1'b0, head_job.down & mask, 1'b0};

   always_comb begin
      for (int c = 0; c < ROW_WIDTH; c++) begin
         nbr[c] = NBR_WIDTH'(up_pad[c])   + NBR_WIDTH'(up_pad[c+1])
                + NBR_WIDTH'(up_pad[c+2]) + NBR_WIDTH'(mid_pad[c])
                + NBR_WIDTH'(mid_pad[c+2]) + NBR_WIDTH'(down_pad[c])
                + NBR_WIDTH'(down_pad[c+1]) + NBR_WIDTH'(down_pad[c+2]);
         next_row[c] = mask[c]
                    && ((nbr[c] == NBR_WIDTH'(BIRTH_COUNT))
                    || (mid_pad[c+1] && nbr[c] == NBR_WIDTH'(SURVIVE_LOW)));
      end
   end

   assign pop          = !queue_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff   <= COLS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            columns_ff <= csr_columns_in_use;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_cells_ff     <= next_row;
         rsp_frame_end_ff <= head_job.frame_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_cells = rsp_cells_ff;
   assign rsp_frame_end  = rsp_frame_end_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !pop)
      else $error("result beat overwritten while stalled");
   assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("popped job produced no result beat");
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (next_row & ~mask) == '0)
      else $error("live cell beyond active columns");
`endif

endmodule

`default_nettype wire

@@ src/life_automaton_row_step.sv @@
`default_nettype none

// One generation of the B3/S23 automaton over a grid with dead borders, one row
// per beat, top row first, req_bottom_row on the last row. Result row r leaves
// once row r+1 has been taken; the bottom row releases the last one or two rows,
// the final one with rsp_frame_end set. Rows are taken one per cycle while the
// job queue has room; a bottom row that follows earlier rows stalls the input
// until its second result is queued. Each job passes through a two-entry job
// queue and the registered result stage, which holds while rsp_stall is high.
// csr_columns_in_use (reset 64, values above 64 act as 64) masks
// stored and incoming rows when each result is formed; columns at or beyond it
// read as dead and come out as zero. Write it only while no result is pending.
module life_automaton_row_step (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [life_pkg::ROW_WIDTH-1:0]  req_row_cells,
   input  wire logic                            req_bottom_row,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [life_pkg::ROW_WIDTH-1:0]       rsp_next_cells,
   output logic                                 rsp_frame_end,
   input  wire logic                            csr_write_enable,
   input  wire logic [life_pkg::COLS_WIDTH-1:0] csr_columns_in_use
);
   import life_pkg::*;

   queue_status_type queue_status;
   job_type          push_job;
   job_type          head_job;
   logic             push_valid;
   logic             pop;

   life_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_row_cells  (req_row_cells),
      .req_bottom_row (req_bottom_row),
      .queue_status   (queue_status),
      .push_valid     (push_valid),
      .push_job       (push_job)
   );

   life_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_valid   (push_valid),
      .push_job     (push_job),
      .pop          (pop),
      .head_job     (head_job),
      .queue_status (queue_status)
   );

   life_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_columns_in_use (csr_columns_in_use),
      .head_job           (head_job),
      .queue_status       (queue_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_next_cells     (rsp_next_cells),
      .rsp_frame_end      (rsp_frame_end)
   );

endmodule

`default_nettype wire

@@ bench/life_row_checker.sv @@
`default_nettype none

module life_row_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  wire logic [life_pkg::ROW_WIDTH-1:0]  req_row_cells,
   input  wire logic                            req_bottom_row,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic [life_pkg::ROW_WIDTH-1:0]  rsp_next_cells,
   input  wire logic                            rsp_frame_end,
   input  wire logic                            csr_write_enable,
   input  wire logic [life_pkg::COLS_WIDTH-1:0] csr_columns_in_use,
   output int                                   mismatch_count,
   output int                                   rows_due
);
   timeunit 1ns;
   timeprecision 1ps;

   import life_pkg::*;

   typedef struct packed {
      logic [ROW_WIDTH-1:0] cells;
      logic                 frame_end;
   } due_row_type;

   due_row_type            next_rows_due[$];
   due_row_type            oldest_row;
   logic [COLS_WIDTH-1:0]  columns;
   logic [ROW_WIDTH-1:0]   row_above;
   logic [ROW_WIDTH-1:0]   row_pending;
   seen_type               rows_held;
   int                     fails = 0;
   int                     results_seen = 0;

   function automatic logic [ROW_WIDTH-1:0] evolve_row(input logic [ROW_WIDTH-1:0] up,
                                                       input logic [ROW_WIDTH-1:0] mid,
                                                       input logic [ROW_WIDTH-1:0] down,
                                                       input logic [COLS_WIDTH-1:0] cols);
      logic [ROW_WIDTH-1:0] mask;
      logic [ROW_WIDTH-1:0] u;
      logic [ROW_WIDTH-1:0] m;
      logic [ROW_WIDTH-1:0] d;
      logic [ROW_WIDTH-1:0] result;
      int                   active;
      int                   live;
      active = (cols > ROW_WIDTH) ? ROW_WIDTH : int'(cols);
      mask = (active >= ROW_WIDTH) ? '1 : ((ROW_WIDTH'(1) << active) - 1);
      u = up & mask;
      m = mid & mask;
      d = down & mask;
      result = '0;
      for (int c = 0; c < ROW_WIDTH; c++) begin
         live = 0;
         for (int k = c - 1; k <= c + 1; k++) begin
            if (k >= 0 && k < ROW_WIDTH) begin
               live += int'(u[k]) + int'(d[k]);
               if (k != c) live += int'(m[k]);
            end
         end
         if (m[c] ? (live == SURVIVE_LOW || live == BIRTH_COUNT) : (live == BIRTH_COUNT))
            result[c] = 1'b1;
      end
      return result & mask;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         next_rows_due.delete();
         columns = COLS_RESET;
         row_above = '0;
         row_pending = '0;
         rows_held = SEEN_NONE;
      end else begin
         if (csr_write_enable) columns = csr_columns_in_use;

         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (next_rows_due.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("result %0d: unexpected beat, cells %h frame_end %b",
                           results_seen, rsp_next_cells, rsp_frame_end);
            end else begin
               oldest_row = next_rows_due.pop_front();
               if (rsp_next_cells !== oldest_row.cells ||
                   rsp_frame_end !== oldest_row.frame_end) begin
                  fails++;
                  if (fails <= 10)
                     $display("result %0d: cells exp %h got %h, frame_end exp %b got %b",
                              results_seen, oldest_row.cells, rsp_next_cells,
                              oldest_row.frame_end, rsp_frame_end);
               end
            end
         end

         if (req_valid && !req_stall) begin
            if (rows_held == SEEN_NONE) begin
               if (req_bottom_row) begin
                  next_rows_due.push_back({evolve_row('0, req_row_cells, '0, columns), 1'b1});
               end else begin
                  row_above = '0;
                  row_pending = req_row_cells;
                  rows_held = SEEN_ONE;
               end
            end else begin
               next_rows_due.push_back({evolve_row(row_above, row_pending, req_row_cells,
                                                   columns), 1'b0});
               row_above = row_pending;
               row_pending = req_row_cells;
               if (req_bottom_row) begin
                  next_rows_due.push_back({evolve_row(row_above, row_pending, '0, columns),
                                           1'b1});
                  row_above = '0;
                  row_pending = '0;
                  rows_held = SEEN_NONE;
               end else begin
                  rows_held = SEEN_TWO;
               end
            end
         end
      end
      mismatch_count <= fails;
      rows_due <= next_rows_due.size();
   end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import life_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ROWS    = 1150;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [ROW_WIDTH-1:0]   req_row_cells = '0;
   logic                   req_bottom_row = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [ROW_WIDTH-1:0]   rsp_next_cells;
   logic                   rsp_frame_end;
   logic                   csr_write_enable = 1'b0;
   logic [COLS_WIDTH-1:0]  csr_columns_in_use = COLS_RESET;

   int   mismatch_count;
   int   rows_due;
   int   quiet_cycles = 0;
   int   rows_sent = 0;
   int   frame_count = 0;
   bit   sender_calm = 1'b0;
   int   hold_token = 0;
   int   hold_seen = 0;
   int   hold_left = 0;
   int   run_left = 0;

   life_automaton_row_step DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_row_cells      (req_row_cells),
      .req_bottom_row     (req_bottom_row),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_next_cells     (rsp_next_cells),
      .rsp_frame_end      (rsp_frame_end),
      .csr_write_enable   (csr_write_enable),
      .csr_columns_in_use (csr_columns_in_use)
   );

   life_row_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_row_cells      (req_row_cells),
      .req_bottom_row     (req_bottom_row),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_next_cells     (rsp_next_cells),
      .rsp_frame_end      (rsp_frame_end),
      .csr_write_enable   (csr_write_enable),
      .csr_columns_in_use (csr_columns_in_use),
      .mismatch_count     (mismatch_count),
      .rows_due           (rows_due)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("life_automaton_row_step verification failed");
         $finish;
      end
   end

   // receiver: random stall runs, plus a long hold whenever the token moves
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         run_left = 0;
         hold_left = 0;
      end else if (hold_seen != hold_token) begin
         hold_seen = hold_token;
         hold_left = 240;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (run_left > 0) begin
         run_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         run_left = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
         run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 8);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (sender_calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic [ROW_WIDTH-1:0] random_row();
      logic [ROW_WIDTH-1:0] a;
      logic [ROW_WIDTH-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return a & b;
         4: return a | b;
         default: return a;
      endcase
   endfunction

   function automatic logic [COLS_WIDTH-1:0] pick_columns();
      case ($urandom_range(0, 7))
         0: return COLS_WIDTH'(0);
         1: return COLS_WIDTH'(1);
         2, 3: return COLS_WIDTH'(64);
         4: return COLS_WIDTH'(127);
         5: return COLS_WIDTH'($urandom_range(65, 126));
         default: return COLS_WIDTH'($urandom_range(1, 64));
      endcase
   endfunction

   task automatic send_row(input logic [ROW_WIDTH-1:0] cells, input logic bottom);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_row_cells <= cells;
      req_bottom_row <= bottom;
      do @(posedge clock); while (!(req_valid && !req_stall));
      rows_sent++;
   endtask

   // drop valid and wait for every outstanding row, then let the pipeline settle
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (rows_due != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_columns(input logic [COLS_WIDTH-1:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_columns_in_use <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_frame(input int height);
      for (int i = 0; i < height; i++)
         send_row(random_row(), i == height - 1);
   endtask

   initial begin
      int height;
      int r;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_row('1, 1'b1);
      send_row('0, 1'b1);
      send_row(64'h2, 1'b0);
      send_row(64'h2, 1'b0);
      send_row(64'h2, 1'b1);
      send_row('1, 1'b0);
      send_row('1, 1'b0);
      send_row('1, 1'b1);
      send_row(64'h8000_0000_0000_0001, 1'b0);
      send_row(64'hC000_0000_0000_0003, 1'b1);
      send_row({32{2'b10}}, 1'b0);
      send_row({32{2'b01}}, 1'b0);
      send_row({32{2'b10}}, 1'b1);
      set_columns(COLS_WIDTH'(0));
      send_row('1, 1'b0);
      send_row('1, 1'b1);
      set_columns(COLS_WIDTH'(100));
      send_row('1, 1'b0);
      send_row(64'h7, 1'b1);
      set_columns(COLS_WIDTH'(1));
      send_row('1, 1'b0);
      send_row('1, 1'b1);
      set_columns(COLS_WIDTH'(127));
      send_row(64'hE000_0000_0000_0007, 1'b1);
      set_columns(COLS_WIDTH'(64));
      send_row('1, 1'b0);
      set_columns(COLS_WIDTH'(10));
      send_row('1, 1'b0);
      send_row('1, 1'b1);
      set_columns(COLS_WIDTH'(64));

      rows_sent = 0;
      while (rows_sent < RANDOM_ROWS) begin
         frame_count++;
         if (frame_count % 12 == 0) set_columns(pick_columns());
         else if (frame_count % 7 == 0) settle();
         sender_calm = (frame_count % 9 == 0);
         r = $urandom_range(0, 19);
         if (frame_count == 20 || frame_count == 90) begin
            hold_token <= hold_token + 1;
            sender_calm = 1'b1;
            height = 30;
         end else if (r < 3) begin
            height = 1;
         end else if (r == 3) begin
            height = $urandom_range(20, 40);
         end else begin
            height = $urandom_range(2, 10);
         end
         send_frame(height);
      end
      sender_calm = 1'b0;

      req_valid <= 1'b0;
      do @(posedge clock); while (rows_due != 0);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && rows_due == 0)
         $display("life_automaton_row_step verification clean");
      else
         $display("life_automaton_row_step verification failed");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
src/life_pkg.sv
src/life_front.sv
src/life_queue.sv
src/life_back.sv
src/life_automaton_row_step.sv
bench/life_row_checker.sv
bench/tb_top.sv
